[hdl/spd_pkg.sv]
// shared constants and types of the packet deframer
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   // sync sequence 's', 'n', 'p'
   localparam logic [7:0] SYNC_S = 8'h73;
   localparam logic [7:0] SYNC_N = 8'h6E;
   localparam logic [7:0] SYNC_P = 8'h70;

   // register indexes on the configuration port
   localparam logic [0:0] REG_FILTER_ENABLE = 1'b0;
   localparam logic [0:0] REG_MATCH_ADDRESS = 1'b1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] data_byte;
      logic [7:0] register_address;
      logic [1:0] byte_in_word;
      logic [7:0] packet_address;
      logic [3:0] word_count;
      logic       has_data_flag;
      logic       batch_flag;
      logic       command_failed;
      logic       checksum_ok;
   } result_type;

endpackage

`default_nettype wire

[hdl/spd_if.sv]
// valid/ready channel interfaces for received bytes and deframed results
`timescale 1ns / 1ps
`default_nettype none

interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [7:0] register_address;
   logic [1:0] byte_in_word;
   logic [7:0] packet_address;
   logic [3:0] word_count;
   logic       has_data_flag;
   logic       batch_flag;
   logic       command_failed;
   logic       checksum_ok;

   modport source (output valid, output result_kind, output data_byte,
                   output register_address, output byte_in_word,
                   output packet_address, output word_count,
                   output has_data_flag, output batch_flag,
                   output command_failed, output checksum_ok,
                   input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input register_address, input byte_in_word,
                   input packet_address, input word_count,
                   input has_data_flag, input batch_flag,
                   input command_failed, input checksum_ok,
                   output ready);
endinterface

`default_nettype wire

[hdl/sync_packet_deframer_sum16_core.sv]
// top level of the sync-framed packet deframer with 16-bit sum check
// takes one received byte per transfer and sustains one byte per clock: a byte
// enters the input register, the framing state machine handles it in a single
// step and any result lands in a two-entry output buffer, so a result reaches
// rsp once its byte has passed the input register and the output buffer. the
// single-step state machine sets the rate; the output buffer lets a new byte be
// taken while a result is still waiting, and input stalls only while both
// buffer entries are held. frames are 's' 'n' 'p', type, address, 4 bytes per
// data word, then a big-endian checksum that is the 16-bit sum of all bytes
// from 's' through the last data byte.
// every data byte gives a data result and every checksum gives an end result,
// unless filtering is on and the packet address differs from match_address.
// registers: filter_enable at byte address 0, match_address at byte address 4
`timescale 1ns / 1ps
`default_nettype none

module sync_packet_deframer_sum16_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   spd_req_if.sink                                 req_ch,
   spd_rsp_if.source                               rsp_ch,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [spd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [spd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [spd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                    pready
);

   // configuration registers
   logic       filter_ff;
   logic [7:0] match_ff;
   logic [0:0] csr_idx;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // output buffer, two entries
   spd_pkg::result_type buf_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;

   logic                room;
   logic                stage_go;
   logic                push;
   logic                pop;
   logic                res_valid;
   spd_pkg::result_type res;
   spd_pkg::result_type head;

   // csr access, always ready, registers written on the access phase
   assign pready  = 1'b1;
   assign csr_idx = paddr[2];

   always_comb begin
      unique case (csr_idx)
         spd_pkg::REG_FILTER_ENABLE: prdata = {31'd0, filter_ff};
         spd_pkg::REG_MATCH_ADDRESS: prdata = {24'd0, match_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= 1'b0;
         match_ff  <= 8'd0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            spd_pkg::REG_FILTER_ENABLE: filter_ff <= pwdata[0];
            spd_pkg::REG_MATCH_ADDRESS: match_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // byte moves on from the input register whenever the buffer has space
   assign room         = (count_ff != 2'd2);
   assign stage_go     = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   spd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (stage_go),
      .rx_byte       (in_byte_ff),
      .filter_enable (filter_ff),
      .match_address (match_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // result buffer
   assign push = stage_go && res_valid;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= res;
      end
   end

   assign head                    = buf_ff[rd_ptr_ff];
   assign rsp_ch.valid            = (count_ff != 2'd0);
   assign rsp_ch.result_kind      = head.result_kind;
   assign rsp_ch.data_byte        = head.data_byte;
   assign rsp_ch.register_address = head.register_address;
   assign rsp_ch.byte_in_word     = head.byte_in_word;
   assign rsp_ch.packet_address   = head.packet_address;
   assign rsp_ch.word_count       = head.word_count;
   assign rsp_ch.has_data_flag    = head.has_data_flag;
   assign rsp_ch.batch_flag       = head.batch_flag;
   assign rsp_ch.command_failed   = head.command_failed;
   assign rsp_ch.checksum_ok      = head.checksum_ok;

   // buffer never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   // a result is only pushed while there is space for it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("result pushed into a full buffer");

   // pointer distance tracks the fill count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("buffer pointers disagree with count");

   // lone push raises the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("buffer count did not follow a push");

endmodule

`default_nettype wire

[hdl/spd_parser.sv]
// framing state machine: one received byte per step, at most one result
`timescale 1ns / 1ps
`default_nettype none

module spd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               filter_enable,
   input  wire logic [7:0]         match_address,
   output logic                    res_valid,
   output spd_pkg::result_type     res
);

   typedef enum logic [2:0] {
      HUNT, SEEK_N, SEEK_P, GET_TYPE, GET_ADDR, GET_DATA, CK_HIGH, CK_LOW
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  addr_ff, addr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [7:0]  ck_high_ff, ck_high_in;
   logic        skip_ff, skip_in;
   logic [3:0]  words;
   logic [5:0]  cnt_inc;

   function automatic logic [3:0] words_of(input logic [7:0] t);
      logic [3:0] w;
      if (!t[7]) begin
         w = 4'd0;
      end else if (t[6]) begin
         w = t[5:2];
      end else begin
         w = 4'd1;
      end
      return w;
   endfunction

   assign words     = words_of(type_ff);
   assign cnt_inc   = cnt_ff + 6'd1;

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      type_in    = type_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      ck_high_in = ck_high_ff;
      skip_in    = skip_ff;
      res_valid  = 1'b0;

      res                  = '0;
      res.packet_address   = addr_ff;
      res.word_count       = words;
      res.has_data_flag    = type_ff[7];
      res.batch_flag       = type_ff[6];
      res.command_failed   = type_ff[0];

      if (step) begin
         unique case (phase_ff)
            SEEK_N, SEEK_P: begin
               if ((phase_ff == SEEK_N && rx_byte == spd_pkg::SYNC_N) ||
                   (phase_ff == SEEK_P && rx_byte == spd_pkg::SYNC_P)) begin
                  sum_in   = sum_ff + {8'd0, rx_byte};
                  phase_in = (phase_ff == SEEK_N) ? SEEK_P : GET_TYPE;
               end else if (rx_byte == spd_pkg::SYNC_S) begin
                  // mismatching byte may itself open a new frame
                  sum_in   = {8'd0, spd_pkg::SYNC_S};
                  phase_in = SEEK_N;
               end else begin
                  phase_in = HUNT;
               end
            end
            GET_TYPE: begin
               type_in  = rx_byte;
               sum_in   = sum_ff + {8'd0, rx_byte};
               phase_in = GET_ADDR;
            end
            GET_ADDR: begin
               addr_in  = rx_byte;
               sum_in   = sum_ff + {8'd0, rx_byte};
               skip_in  = filter_enable && (rx_byte != match_address);
               cnt_in   = 6'd0;
               phase_in = (words != 4'd0) ? GET_DATA : CK_HIGH;
            end
            GET_DATA: begin
               sum_in = sum_ff + {8'd0, rx_byte};
               if (!skip_ff) begin
                  res_valid            = 1'b1;
                  res.result_kind      = spd_pkg::KIND_DATA;
                  res.data_byte        = rx_byte;
                  res.register_address = addr_ff + {4'd0, cnt_ff[5:2]};
                  res.byte_in_word     = cnt_ff[1:0];
               end
               cnt_in = cnt_inc;
               if (cnt_inc >= {words, 2'b00}) begin
                  phase_in = CK_HIGH;
               end
            end
            CK_HIGH: begin
               ck_high_in = rx_byte;
               phase_in   = CK_LOW;
            end
            CK_LOW: begin
               if (!skip_ff) begin
                  res_valid       = 1'b1;
                  res.result_kind = spd_pkg::KIND_END;
                  res.checksum_ok = ({ck_high_ff, rx_byte} == sum_ff);
               end
               skip_in  = 1'b0;
               phase_in = HUNT;
            end
            HUNT: begin
               if (rx_byte == spd_pkg::SYNC_S) begin
                  sum_in   = {8'd0, spd_pkg::SYNC_S};
                  phase_in = SEEK_N;
               end
            end
            default: phase_in = HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
      end
      sum_ff     <= sum_in;
      type_ff    <= type_in;
      addr_ff    <= addr_in;
      cnt_ff     <= cnt_in;
      ck_high_ff <= ck_high_in;
   end

endmodule

`default_nettype wire
